// ----- rtl/core/utf8v_pkg.sv -----
// Shared types and constants for the UTF-8 identifier validator.
`default_nettype none

package utf8v_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned ACC_W   = 21;

    localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd128;

    typedef enum logic [2:0] {
        V_OK     = 3'd0,
        V_LENGTH = 3'd1,
        V_NUL    = 3'd2,
        V_LEAD   = 3'd3,
        V_TRUNC  = 3'd4,
        V_CONT   = 3'd5,
        V_SCALAR = 3'd6
    } t_verdict;

    // Per-string decode state.
    typedef struct packed {
        logic [COUNT_W-1:0] bytes_seen;
        logic [1:0]         pend;
        logic [ACC_W-1:0]   acc;
        logic [1:0]         min_cls;
        t_verdict           first_err;
        logic               cont_err;
        logic               nul_seen;
        logic               len_ovf;
    } t_state;

    // Result word handed to the output register.
    typedef struct packed {
        t_verdict           verdict;
        logic [COUNT_W-1:0] byte_count;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/utf8v_step.sv -----
// Per-word decode: next string state and verdict for one input word.
`default_nettype none

module utf8v_step
    import utf8v_pkg::*;
(
    input  var t_state            i_state,
    input  wire [BYTE_W-1:0]      i_data_byte,
    input  wire                   i_last,
    input  wire                   i_end_only,
    input  wire [COUNT_W-1:0]     i_max_length,
    output t_state                o_next,
    output logic                  o_emit,
    output t_result               o_result
);

    localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
    localparam logic [ACC_W-1:0]  MIN_CLS1 = 21'h00080;
    localparam logic [ACC_W-1:0]  MIN_CLS2 = 21'h00800;
    localparam logic [ACC_W-1:0]  MIN_CLS3 = 21'h10000;
    localparam logic [ACC_W-1:0]  MAX_SCAL = 21'h10FFFF;
    localparam logic [ACC_W-1:0]  SURR_LO  = 21'h0D800;
    localparam logic [ACC_W-1:0]  SURR_HI  = 21'h0DFFF;

    t_state           tk;
    logic [ACC_W-1:0] cls_min;
    t_verdict         verdict;

    always_comb begin
        tk      = i_state;
        cls_min = MIN_CLS3;
        if (!i_end_only) begin
            if (tk.bytes_seen == '1) begin
                tk.len_ovf = 1'b1;
            end else begin
                tk.bytes_seen = tk.bytes_seen + COUNT_W'(1);
            end
            if (i_data_byte == '0) begin
                tk.nul_seen = 1'b1;
            end
            // Once an error is latched, bytes are only counted and checked for NUL.
            if (i_state.first_err == V_OK) begin
                if (i_state.pend == 2'd0) begin
                    if (!i_data_byte[7]) begin
                        tk.pend = 2'd0;
                    end else if (i_data_byte >= LEAD2_LO && i_data_byte <= LEAD2_HI) begin
                        tk.pend    = 2'd1;
                        tk.acc     = ACC_W'(i_data_byte[4:0]);
                        tk.min_cls = 2'd1;
                    end else if (i_data_byte >= LEAD3_LO && i_data_byte <= LEAD3_HI) begin
                        tk.pend    = 2'd2;
                        tk.acc     = ACC_W'(i_data_byte[3:0]);
                        tk.min_cls = 2'd2;
                    end else if (i_data_byte >= LEAD4_LO && i_data_byte <= LEAD4_HI) begin
                        tk.pend    = 2'd3;
                        tk.acc     = ACC_W'(i_data_byte[2:0]);
                        tk.min_cls = 2'd3;
                    end else begin
                        tk.first_err = V_LEAD;
                    end
                end else begin
                    if (i_data_byte[7:6] != 2'b10) begin
                        tk.cont_err = 1'b1;
                    end
                    tk.acc  = {i_state.acc[ACC_W-7:0], i_data_byte[5:0]};
                    tk.pend = i_state.pend - 2'd1;
                    if (tk.pend == 2'd0) begin
                        priority if (i_state.min_cls == 2'd1) begin
                            cls_min = MIN_CLS1;
                        end else if (i_state.min_cls == 2'd2) begin
                            cls_min = MIN_CLS2;
                        end else begin
                            cls_min = MIN_CLS3;
                        end
                        if (tk.cont_err) begin
                            tk.first_err = V_CONT;
                        end else if (tk.acc < cls_min || tk.acc > MAX_SCAL ||
                                     (tk.acc >= SURR_LO && tk.acc <= SURR_HI)) begin
                            tk.first_err = V_SCALAR;
                        end
                        tk.cont_err = 1'b0;
                        tk.acc      = '0;
                        tk.min_cls  = 2'd0;
                    end
                end
            end
        end
    end

    always_comb begin
        priority if (tk.bytes_seen == '0 || tk.len_ovf || tk.bytes_seen > i_max_length) begin
            verdict = V_LENGTH;
        end else if (tk.nul_seen) begin
            verdict = V_NUL;
        end else if (tk.first_err != V_OK) begin
            verdict = tk.first_err;
        end else if (tk.pend != 2'd0) begin
            verdict = V_TRUNC;
        end else begin
            verdict = V_OK;
        end
    end

    assign o_emit              = i_end_only | i_last;
    assign o_result.verdict    = verdict;
    assign o_result.byte_count = tk.bytes_seen;
    assign o_next              = o_emit ? t_state'('0) : tk;

endmodule

`default_nettype wire

// ----- rtl/core/utf8v_outreg.sv -----
// Result register with valid/ready toward the receiver.
`default_nettype none

module utf8v_outreg
    import utf8v_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_load,
    input  var t_result  i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire          i_ready,
    output t_result      o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_identifier_validator_top.sv -----
// Top level of the UTF-8 identifier validator.
//
// Input channel: one word per handshake (i_in_valid / o_in_ready) carrying a
// byte, a last flag and an end_only flag. A string ends with a word that has
// last or end_only set; that word produces exactly one verdict word on the
// output channel (o_out_valid / i_out_ready) with the saturating byte count.
// Words without an end mark produce nothing.
// Throughput is one word per cycle unless the receiver stalls. An accepted
// word is held in the input register, decoded from there against the string
// state and, if it ends the string, loaded into the result register, which
// drives the verdict onto the output channel.
// If the receiver stalls, the result register holds the verdict; the input
// register still drains words that end nothing, and fills up behind a word
// that needs the result register, at which point o_in_ready drops.
// Reset clears the string state and both valid flags and sets max_length to
// 128. i_cfg_we writes max_length at once; write it only while idle.
`default_nettype none

module utf8_identifier_validator_top
    import utf8v_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [COUNT_W-1:0]   i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire [BYTE_W-1:0]    i_data_byte,
    input  wire                 i_last,
    input  wire                 i_end_only,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [2:0]          o_verdict,
    output logic [COUNT_W-1:0]  o_byte_count
);

    logic [COUNT_W-1:0] r_max_length;
    logic               r_in_valid;
    logic               n_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;
    logic               r_in_end;
    t_state             r_state;
    t_state             n_state;
    logic               emit;
    logic               out_free;
    logic               process;
    t_result            step_result;
    t_result            out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_data;
        end
    end

    utf8v_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_last       (r_in_last),
        .i_end_only   (r_in_end),
        .i_max_length (r_max_length),
        .o_next       (n_state),
        .o_emit       (emit),
        .o_result     (step_result)
    );

    // A word that ends nothing never waits on the result register.
    assign process    = r_in_valid && (!emit || out_free);
    assign o_in_ready = !r_in_valid || process;
    assign n_in_valid = (i_in_valid && o_in_ready) || (r_in_valid && !process);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (process) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
            r_in_end  <= i_end_only;
        end
    end

    utf8v_outreg u_outreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (process && emit),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_verdict    = out_result.verdict;
    assign o_byte_count = out_result.byte_count;

    // An empty string can only ever be reported as a length failure.
    a_empty_is_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count == '0 |-> o_verdict == V_LENGTH)
        else $error("empty string with verdict other than bad length");

    // A sequence is open exactly when a class is recorded for it.
    a_pend_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pend == 2'd0) == (r_state.min_cls == 2'd0))
        else $error("pending count and sequence class disagree");

    // A latched UTF-8 error holds until the string ends.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && !emit && r_state.first_err != V_OK
        |=> r_state.first_err == $past(r_state.first_err))
        else $error("first error changed inside a string");

    // A held input word is never dropped.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !process |=> r_in_valid)
        else $error("input word lost while waiting");

endmodule

`default_nettype wire
